>>> rtl/core/g3_fax_eol_pad_dle_stuffer_core_defines.svh
// Assertion helpers shared by the stuffer core.
`ifndef G3_FAX_EOL_PAD_DLE_STUFFER_CORE_DEFINES_SVH
`define G3_FAX_EOL_PAD_DLE_STUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define G3FAX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define G3FAX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/g3fax_pkg.sv
`timescale 1ns / 1ps
package g3fax_pkg;

  localparam int unsigned G3FAX_MAX_PAD = 61;

  localparam logic [4:0] EolZeros     = 5'd11;
  localparam logic [4:0] ZeroByteBits = 5'd8;
  localparam logic [7:0] DleCode      = 8'h10;
  localparam logic [5:0] LineSat      = 6'd63;

  typedef enum logic [1:0] {
    REG_PAD_LENGTH     = 2'd0,
    REG_DLE_ESCAPE_ON  = 2'd1,
    REG_BIT_REVERSE_ON = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       page_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [3:0] zero_run;
    logic [5:0] line_bytes;
  } line_state_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [7:0] ob;
    logic       dle;
  } job_t;

  function automatic logic [3:0] lead_zeros(input logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    n   = 4'd0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && !b[i]) begin
        n = n + 4'd1;
      end else begin
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] trail_zeros(input logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    n   = 4'd0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && !b[i]) begin
        n = n + 4'd1;
      end else begin
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/g3fax_step.sv
`timescale 1ns / 1ps
module g3fax_step import g3fax_pkg::*; #(
  parameter int unsigned MAX_PAD = G3FAX_MAX_PAD
) (
  input  in_t         item_i,
  input  line_state_t state_i,
  input  logic [5:0]  pad_length_i,
  input  logic        dle_escape_on_i,
  input  logic        bit_reverse_on_i,
  output line_state_t state_o,
  output job_t        job_o
);

  localparam logic [5:0] MaxPad = 6'(MAX_PAD);

  logic [5:0] pad;
  logic [5:0] lb_inc;
  logic [4:0] zr_sum;
  logic [4:0] eol_sum;
  logic       eol;
  logic [7:0] b;

  assign b      = item_i.data_byte;
  assign pad    = (pad_length_i > MaxPad) ? MaxPad : pad_length_i;
  assign lb_inc = (state_i.line_bytes == LineSat) ? LineSat : state_i.line_bytes + 6'd1;
  assign zr_sum = {1'b0, state_i.zero_run} + ZeroByteBits;
  assign eol_sum = {1'b0, state_i.zero_run} + {1'b0, lead_zeros(b)};
  assign eol    = (b != 8'd0) && (eol_sum >= EolZeros);

  always_comb begin
    state_o    = state_i;
    job_o.fill = 6'd0;
    if (b == 8'd0) begin
      state_o.zero_run   = (zr_sum > EolZeros) ? EolZeros[3:0] : zr_sum[3:0];
      state_o.line_bytes = lb_inc;
    end else begin
      state_o.zero_run = trail_zeros(b);
      if (eol) begin
        // Pad the line that just ended up to the minimum length.
        if (lb_inc < pad) begin
          job_o.fill = pad - lb_inc;
        end
        state_o.line_bytes = 6'd0;
      end else begin
        state_o.line_bytes = lb_inc;
      end
    end
    if (item_i.page_last) begin
      state_o.zero_run   = 4'd0;
      state_o.line_bytes = LineSat;
    end
    job_o.ob  = bit_reverse_on_i ? reverse8(b) : b;
    job_o.dle = dle_escape_on_i && (job_o.ob == DleCode);
  end

endmodule

>>> rtl/core/g3_fax_eol_pad_dle_stuffer_core.sv
`timescale 1ns / 1ps
// G3 fax end-of-line padding and DLE stuffing core.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one coded byte per
// transfer, with page_last marking the final byte of a page. Output channel
// (out_valid_o / out_stall_i / out_data_o) gives zero fill bytes, then the
// (optionally bit-reversed) data byte, then a second DLE when escaping applies;
// run_last marks the final output of each input byte.
// The first output of an input byte is offered in the cycle after its
// transfer. Throughput: one input byte per cycle if each byte makes one output
// and the receiver does not stall; a byte with F fill bytes and D doubled DLEs
// (0 or 1) holds the input over 1 + F + D outputs via the single job register.
// The job register frees in the cycle its last output transfers, so the next
// byte is taken in that same cycle.
// Configuration: cfg_we_i writes register cfg_index_i (0 pad length,
// 1 DLE escape, 2 bit reverse) from cfg_wdata_i; write only while idle.
// Reset: no job pending, pad length 0, escape and reverse on, line state at
// page start (first line end of a page is never padded).
// Receiver stall holds the current output and, through the job register,
// stalls the input side; no output is lost or repeated.
module g3_fax_eol_pad_dle_stuffer_core import g3fax_pkg::*; #(
  parameter int unsigned MAX_PAD = G3FAX_MAX_PAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

`include "g3_fax_eol_pad_dle_stuffer_core_defines.svh"

  logic [5:0]  pad_length_q;
  logic        dle_escape_on_q;
  logic        bit_reverse_on_q;
  line_state_t state_q, state_d;
  job_t        job_q, job_d;
  job_t        new_job;
  logic        job_valid_q, job_valid_d;
  logic        byte_sent_q, byte_sent_d;
  logic        in_xfer, out_xfer, job_done;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_length_q     <= 6'd0;
      dle_escape_on_q  <= 1'b1;
      bit_reverse_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAD_LENGTH:     pad_length_q     <= cfg_wdata_i;
        REG_DLE_ESCAPE_ON:  dle_escape_on_q  <= cfg_wdata_i[0];
        REG_BIT_REVERSE_ON: bit_reverse_on_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Line state update and job build for the byte at the input.
  g3fax_step #(
    .MAX_PAD(MAX_PAD)
  ) u_step (
    .item_i          (in_data_i),
    .state_i         (state_q),
    .pad_length_i    (pad_length_q),
    .dle_escape_on_i (dle_escape_on_q),
    .bit_reverse_on_i(bit_reverse_on_q),
    .state_o         (state_d),
    .job_o           (new_job)
  );

  // Output selection: fill zeros first, then the byte, then the extra DLE.
  always_comb begin
    out_valid_o = job_valid_q;
    if (job_q.fill != 6'd0) begin
      out_data_o.out_byte = 8'd0;
      out_data_o.run_last = 1'b0;
    end else if (!byte_sent_q) begin
      out_data_o.out_byte = job_q.ob;
      out_data_o.run_last = !job_q.dle;
    end else begin
      out_data_o.out_byte = DleCode;
      out_data_o.run_last = 1'b1;
    end
  end

  assign out_xfer   = job_valid_q && !out_stall_i;
  assign job_done   = out_xfer && out_data_o.run_last;
  // Accept a new byte when the job register is empty or drains this cycle.
  assign in_stall_o = job_valid_q && !job_done;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    byte_sent_d = byte_sent_q;
    if (out_xfer) begin
      if (job_q.fill != 6'd0) begin
        job_d.fill = job_q.fill - 6'd1;
      end else if (!byte_sent_q) begin
        byte_sent_d = 1'b1;
      end
      if (job_done) begin
        job_valid_d = 1'b0;
      end
    end
    if (in_xfer) begin
      job_d       = new_job;
      job_valid_d = 1'b1;
      byte_sent_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q        <= 1'b0;
      byte_sent_q        <= 1'b0;
      state_q.zero_run   <= 4'd0;
      state_q.line_bytes <= LineSat;
    end else begin
      job_valid_q <= job_valid_d;
      byte_sent_q <= byte_sent_d;
      if (in_xfer) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  `G3FAX_ASSERT_SAME(a_fill_is_zero, out_valid_o && (job_q.fill != 6'd0), out_data_o.out_byte == 8'd0 && !out_data_o.run_last, "fill output not a plain zero")
  `G3FAX_ASSERT_SAME(a_stall_needs_job, in_stall_o, out_valid_o, "input stalled with no pending output")
  `G3FAX_ASSERT_NEXT(a_drain_empties, job_done && !in_xfer, !out_valid_o, "output still valid after last transfer")
  `G3FAX_ASSERT_NEXT(a_mid_job_holds, out_xfer && !out_data_o.run_last, out_valid_o, "job ended before its last output")

endmodule
